[design/lpsc_pkg.sv]
// shared types and constants for the lsb pixel steganography codec
`default_nettype none

package lpsc_pkg;

    localparam int BITS_PER_CHAN = 2;
    localparam int CHANNELS      = 3;
    localparam int PIX_BITS      = CHANNELS * BITS_PER_CHAN;
    localparam int CHAN_W        = 8;
    localparam int BUF_W         = 32;
    localparam int PEND_W        = 6;
    localparam int CNT_W         = 25;
    localparam int BIT_W         = CNT_W + $clog2(PIX_BITS) + 1;
    localparam int MAXB_W        = BIT_W - 3;
    localparam int K_W           = $clog2(PIX_BITS + 1);
    localparam int MAX_BYTES_OUT = 3;
    localparam int NOUT_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int LOAD_LIMIT    = BUF_W - CHAN_W;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 2'd2;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_BYTE  = 1'b1
    } kind_t;

    typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_t;

    // one item's worth of results, drained one transaction at a time
    typedef struct packed {
        kind_t                              kind;
        pix_t                               pix;
        logic                               too_large;
        logic [MAX_BYTES_OUT-1:0][CHAN_W-1:0] bytes;
        logic [NOUT_W-1:0]                  count;
    } res_t;

endpackage

`default_nettype wire

[design/lpsc_embed.sv]
// embed datapath: replaces low channel bits with buffered payload bits
`default_nettype none

module lpsc_embed (
    input  logic [lpsc_pkg::BUF_W-1:0]  buf_in,
    input  logic [lpsc_pkg::PEND_W-1:0] pending_in,
    input  logic [lpsc_pkg::BIT_W-1:0]  need,
    input  logic [lpsc_pkg::BIT_W-1:0]  done,
    input  logic                        big,
    input  lpsc_pkg::pix_t              pix_in,
    output lpsc_pkg::pix_t              pix_out,
    output logic [lpsc_pkg::BUF_W-1:0]  buf_out,
    output logic [lpsc_pkg::PEND_W-1:0] pending_out
);
    import lpsc_pkg::*;

    logic [BIT_W:0]  left;
    logic [K_W-1:0]  k;

    always_comb
    begin
        left = {1'b0, need} - {1'b0, done};
        if (big || left[BIT_W] || (left == '0))
        begin
            k = '0;
        end
        else if (left >= (BIT_W + 1)'(PIX_BITS))
        begin
            k = K_W'(PIX_BITS);
        end
        else
        begin
            k = left[K_W-1:0];
        end
    end

    always_comb
    begin
        pix_out = pix_in;
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int b = 0; b < BITS_PER_CHAN; b++)
            begin
                if (k > K_W'(c * BITS_PER_CHAN + b))
                begin
                    pix_out[c][b] = buf_in[c * BITS_PER_CHAN + b];
                end
            end
        end
    end

    assign buf_out     = buf_in >> k;
    assign pending_out = (pending_in > PEND_W'(k)) ? (pending_in - PEND_W'(k)) : '0;

endmodule

`default_nettype wire

[design/lpsc_extract.sv]
// extract datapath: packs a pixel's low bits and splits off whole bytes
`default_nettype none

module lpsc_extract (
    input  logic [lpsc_pkg::BUF_W-1:0]  buf_in,
    input  logic [lpsc_pkg::PEND_W-1:0] pending_in,
    input  lpsc_pkg::pix_t              pix_in,
    input  logic [lpsc_pkg::CNT_W-1:0]  given_in,
    input  logic [lpsc_pkg::MAXB_W-1:0] max_bytes,
    input  logic                        last,
    output logic [lpsc_pkg::BUF_W-1:0]  buf_out,
    output logic [lpsc_pkg::PEND_W-1:0] pending_out,
    output logic [lpsc_pkg::CNT_W-1:0]  given_out,
    output logic [lpsc_pkg::MAX_BYTES_OUT-1:0][lpsc_pkg::CHAN_W-1:0] bytes,
    output logic [lpsc_pkg::NOUT_W-1:0] count
);
    import lpsc_pkg::*;

    logic [PIX_BITS-1:0] pix_bits;
    logic [BUF_W-1:0]    acc;
    logic [PEND_W:0]     pend_sum;
    logic [PEND_W-1:0]   pend_a;
    logic [NOUT_W:0]     avail;
    logic [MAXB_W-1:0]   diff;
    logic [NOUT_W-1:0]   room;
    logic [NOUT_W-1:0]   n;
    logic                flush;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int b = 0; b < BITS_PER_CHAN; b++)
            begin
                pix_bits[c * BITS_PER_CHAN + b] = pix_in[c][b];
            end
        end
    end

    // bits past the top of the buffer are lost
    always_comb
    begin
        acc      = buf_in | (BUF_W'(pix_bits) << pending_in);
        pend_sum = (PEND_W + 1)'(pending_in) + (PEND_W + 1)'(PIX_BITS);
        pend_a   = (pend_sum > (PEND_W + 1)'(BUF_W)) ? PEND_W'(BUF_W) : pend_sum[PEND_W-1:0];
        avail    = (NOUT_W + 1)'(pend_a >> 3);
    end

    always_comb
    begin
        diff = max_bytes - MAXB_W'(given_in);
        if (MAXB_W'(given_in) >= max_bytes)
        begin
            room = '0;
        end
        else if (diff >= MAXB_W'(MAX_BYTES_OUT))
        begin
            room = NOUT_W'(MAX_BYTES_OUT);
        end
        else
        begin
            room = diff[NOUT_W-1:0];
        end
        n = (avail < (NOUT_W + 1)'(room)) ? avail[NOUT_W-1:0] : room;
    end

    // partial byte goes out only on the final pixel when nothing else was given
    assign flush = last && (n == '0) && (given_in == '0)
                   && (pend_a != '0) && (pend_a < PEND_W'(8));

    always_comb
    begin
        for (int i = 0; i < MAX_BYTES_OUT; i++)
        begin
            bytes[i] = acc[i * CHAN_W +: CHAN_W];
        end
        if (flush)
        begin
            buf_out     = '0;
            pending_out = '0;
            given_out   = given_in;
            count       = NOUT_W'(1);
        end
        else
        begin
            buf_out     = acc >> {n, 3'b000};
            pending_out = pend_a - PEND_W'({n, 3'b000});
            given_out   = given_in + CNT_W'(n);
            count       = n;
        end
    end

endmodule

`default_nettype wire

[design/lpsc_out_buf.sv]
// result register: holds one item's results and drains them in order
`default_nettype none

module lpsc_out_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  lpsc_pkg::res_t             res,
    input  logic                       out_stall,
    output logic                       can_load,
    output logic                       out_valid,
    output logic                       kind,
    output lpsc_pkg::pix_t             pix,
    output logic [lpsc_pkg::CHAN_W-1:0] data_byte,
    output logic                       too_large,
    output logic                       last
);
    import lpsc_pkg::*;

    logic [NOUT_W-1:0] cnt_reg;
    logic [NOUT_W-1:0] cnt_next;
    res_t              data_reg;
    res_t              data_next;
    logic              take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign can_load  = (cnt_reg == '0) || ((cnt_reg == NOUT_W'(1)) && take);
    assign last      = (cnt_reg == NOUT_W'(1));

    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (load)
        begin
            cnt_next  = res.count;
            data_next = res;
        end
        else if (take)
        begin
            cnt_next       = cnt_reg - NOUT_W'(1);
            data_next.bytes = {CHAN_W'(0), data_reg.bytes[MAX_BYTES_OUT-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        kind = data_reg.kind;
        if (data_reg.kind == KIND_PIXEL)
        begin
            pix       = data_reg.pix;
            data_byte = '0;
            too_large = data_reg.too_large;
        end
        else
        begin
            pix       = '0;
            data_byte = data_reg.bytes[0];
            too_large = 1'b0;
        end
    end

endmodule

`default_nettype wire

[design/lsb_pixel_stego_codec.sv]
// top level of the lsb pixel steganography codec
`default_nettype none

// LSB steganography codec for a raster of RGB pixels. Payload bits sit in the
// low two bits of each channel, red then green then blue, each channel from
// bit 0 up, and each payload byte is used low bit first. mode 0 embeds: load
// transactions (cmd 0) push payload bytes into a 32-bit bit buffer (a byte is
// dropped when fewer than 8 bits are free), and each pixel transaction (cmd 1)
// returns the pixel with its low bits replaced until payload_bytes*8 bits have
// been placed; after that pixels pass unchanged. If the payload is larger than
// pixel_total*6 bits, every pixel passes unchanged with too_large set. mode 1
// extracts: each pixel's low bits are appended to the buffer and up to three
// whole bytes come out (kind 1), until capacity/8 bytes have been given; on
// the last pixel of the image a partial byte is flushed only if no byte was
// ever given. Loads and pixels past the end of the image in extract mode give
// no result. The buffer and counters survive mode changes and config writes.
// Rate: one transaction per clock while in_stall is low, through an input
// register, the single-pass datapath and the result register. The result
// register drains one result per clock while out_stall is low, so an extract
// pixel that gives bytes stalls the input side until its last byte is taken.
// Configuration is a write-only port (index 0 mode, 1 pixel_total, 2
// payload_bytes) to be written only while the codec is idle; capacity
// figures are formed at write time.
module lsb_pixel_stego_codec (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lpsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpsc_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [lpsc_pkg::CHAN_W-1:0]          payload_byte,
    input  logic [lpsc_pkg::CHAN_W-1:0]          in_red,
    input  logic [lpsc_pkg::CHAN_W-1:0]          in_green,
    input  logic [lpsc_pkg::CHAN_W-1:0]          in_blue,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [lpsc_pkg::CHAN_W-1:0]          out_red,
    output logic [lpsc_pkg::CHAN_W-1:0]          out_green,
    output logic [lpsc_pkg::CHAN_W-1:0]          out_blue,
    output logic [lpsc_pkg::CHAN_W-1:0]          out_byte,
    output logic                                 too_large,
    output logic                                 last_of_run
);
    import lpsc_pkg::*;

    // configuration and figures derived at write time
    logic               mode_reg;
    logic [CNT_W-1:0]   pixel_total_reg;
    logic [CNT_W-1:0]   payload_bytes_reg;
    logic [BIT_W-1:0]   cap_reg;
    logic [MAXB_W-1:0]  max_bytes_reg;
    logic [BIT_W-1:0]   cap_wr;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               cmd_reg;
    logic [CHAN_W-1:0]  pbyte_reg;
    pix_t               pix_reg;
    logic               in_take;
    logic               adv;

    // codec state
    logic [BUF_W-1:0]   buf_reg;
    logic [BUF_W-1:0]   buf_next;
    logic [PEND_W-1:0]  pending_reg;
    logic [PEND_W-1:0]  pending_next;
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   seen_next;
    logic [BIT_W-1:0]   done_reg;
    logic [BIT_W-1:0]   done_next;
    logic [CNT_W-1:0]   given_reg;
    logic [CNT_W-1:0]   given_next;

    // datapath
    logic [BIT_W-1:0]   need;
    logic               big;
    logic               in_frame;
    logic               last_pix;
    pix_t               emb_pix;
    logic [BUF_W-1:0]   emb_buf;
    logic [PEND_W-1:0]  emb_pending;
    logic [BUF_W-1:0]   ext_buf;
    logic [PEND_W-1:0]  ext_pending;
    logic [CNT_W-1:0]   ext_given;
    logic [MAX_BYTES_OUT-1:0][CHAN_W-1:0] ext_bytes;
    logic [NOUT_W-1:0]  ext_count;
    res_t               res;
    logic               can_load;
    pix_t               out_pix;

    // capacity = pixels * bits per pixel
    assign cap_wr = BIT_W'(cfg_data) * BIT_W'(PIX_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_EMBED;
            pixel_total_reg   <= CNT_W'(1);
            payload_bytes_reg <= '0;
            cap_reg           <= BIT_W'(PIX_BITS);
            max_bytes_reg     <= MAXB_W'(PIX_BITS / 8);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_PIXEL_TOTAL)
            begin
                pixel_total_reg <= cfg_data;
                cap_reg         <= cap_wr;
                max_bytes_reg   <= cap_wr[BIT_W-1:3];
            end
            else if (cfg_index == REG_PAYLOAD_BYTES)
            begin
                payload_bytes_reg <= cfg_data;
            end
        end
    end

    // input register: stalls only while the result register cannot take the item
    assign adv           = in_valid_reg && can_load;
    assign in_stall      = in_valid_reg && !can_load;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= cmd;
            pbyte_reg <= payload_byte;
            pix_reg   <= {in_blue, in_green, in_red};
        end
    end

    assign need     = BIT_W'({payload_bytes_reg, 3'b000});
    assign big      = need > cap_reg;
    assign in_frame = seen_reg < pixel_total_reg;
    assign last_pix = (seen_reg + CNT_W'(1)) == pixel_total_reg;

    lpsc_embed u_embed (
        .buf_in      (buf_reg),
        .pending_in  (pending_reg),
        .need        (need),
        .done        (done_reg),
        .big         (big),
        .pix_in      (pix_reg),
        .pix_out     (emb_pix),
        .buf_out     (emb_buf),
        .pending_out (emb_pending)
    );

    lpsc_extract u_extract (
        .buf_in      (buf_reg),
        .pending_in  (pending_reg),
        .pix_in      (pix_reg),
        .given_in    (given_reg),
        .max_bytes   (max_bytes_reg),
        .last        (last_pix),
        .buf_out     (ext_buf),
        .pending_out (ext_pending),
        .given_out   (ext_given),
        .bytes       (ext_bytes),
        .count       (ext_count)
    );

    // state update and result bundle for the item leaving the input register
    always_comb
    begin
        buf_next      = buf_reg;
        pending_next  = pending_reg;
        seen_next     = seen_reg;
        done_next     = done_reg;
        given_next    = given_reg;
        res.kind      = KIND_PIXEL;
        res.pix       = '0;
        res.too_large = 1'b0;
        res.bytes     = '0;
        res.count     = '0;
        if (adv)
        begin
            if (cmd_reg == CMD_LOAD)
            begin
                // new byte sits just above the pending bits
                if (pending_reg <= PEND_W'(LOAD_LIMIT))
                begin
                    buf_next     = buf_reg | (BUF_W'(pbyte_reg) << pending_reg);
                    pending_next = pending_reg + PEND_W'(CHAN_W);
                end
            end
            else if (mode_reg == MODE_EMBED)
            begin
                buf_next      = emb_buf;
                pending_next  = emb_pending;
                res.pix       = emb_pix;
                res.too_large = big;
                res.count     = NOUT_W'(1);
                if (in_frame)
                begin
                    seen_next = seen_reg + CNT_W'(1);
                    done_next = done_reg + BIT_W'(PIX_BITS);
                end
            end
            else if (in_frame)
            begin
                buf_next     = ext_buf;
                pending_next = ext_pending;
                given_next   = ext_given;
                seen_next    = seen_reg + CNT_W'(1);
                done_next    = done_reg + BIT_W'(PIX_BITS);
                res.kind     = KIND_BYTE;
                res.bytes    = ext_bytes;
                res.count    = ext_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            pending_reg <= '0;
            seen_reg    <= '0;
            done_reg    <= '0;
            given_reg   <= '0;
        end
        else
        begin
            buf_reg     <= buf_next;
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
            done_reg    <= done_next;
            given_reg   <= given_next;
        end
    end

    lpsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv),
        .res       (res),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .kind      (kind),
        .pix       (out_pix),
        .data_byte (out_byte),
        .too_large (too_large),
        .last      (last_of_run)
    );

    assign out_red   = out_pix[0];
    assign out_green = out_pix[1];
    assign out_blue  = out_pix[2];

endmodule

`default_nettype wire

[bench/lpsc_checker.sv]
// transaction monitor, prediction and result comparison for the lsb stego codec
`timescale 1ns / 1ps

module lpsc_checker
    import lpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 cmd,
    input  logic [CHAN_W-1:0]    payload_byte,
    input  logic [CHAN_W-1:0]    in_red,
    input  logic [CHAN_W-1:0]    in_green,
    input  logic [CHAN_W-1:0]    in_blue,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 kind,
    input  logic [CHAN_W-1:0]    out_red,
    input  logic [CHAN_W-1:0]    out_green,
    input  logic [CHAN_W-1:0]    out_blue,
    input  logic [CHAN_W-1:0]    out_byte,
    input  logic                 too_large,
    input  logic                 last_of_run,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        kind_t             kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] data_byte;
        logic              big;
        logic              last;
    } stego_res_t;

    // shadow registers
    mode_t            cur_mode;
    logic [CNT_W-1:0] img_pixels;
    logic [CNT_W-1:0] msg_bytes;

    // shadow codec state
    logic [BUF_W-1:0] bit_buf;
    int               buf_bits;
    logic [CNT_W-1:0] pixels_done;
    logic [CNT_W-1:0] bytes_out;

    stego_res_t stego_results [$];
    int         fails;
    int         reported;

    assign fail_count = fails;
    assign pending    = stego_results.size();

    task automatic stego_predict(input logic c, input logic [CHAN_W-1:0] pb,
                                 input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                 input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] ch [CHANNELS];
        logic [63:0]       cap_bits;
        logic [63:0]       need;
        logic [63:0]       placed;
        logic [63:0]       left;
        logic [63:0]       acc;
        int                k;
        int                n;
        int                pend;
        logic              in_image;
        logic              big;
        logic              at_end;
        stego_res_t        res;
        stego_res_t        outs [MAX_BYTES_OUT];

        if (c == CMD_LOAD) begin
            if (buf_bits <= LOAD_LIMIT) begin
                bit_buf  = bit_buf | (BUF_W'(pb) << buf_bits);
                buf_bits = buf_bits + CHAN_W;
            end
            return;
        end

        ch[0]    = r;
        ch[1]    = g;
        ch[2]    = b;
        cap_bits = 64'(img_pixels) * PIX_BITS;
        in_image = pixels_done < img_pixels;

        if (cur_mode == MODE_EMBED) begin
            need   = 64'(msg_bytes) * 8;
            placed = 64'(pixels_done) * PIX_BITS;
            big    = need > cap_bits;
            if (!big && need > placed) begin
                left = need - placed;
                k    = (left < PIX_BITS) ? int'(left) : PIX_BITS;
                for (int idx = 0; idx < k; idx++)
                    ch[idx / BITS_PER_CHAN][idx % BITS_PER_CHAN] = bit_buf[idx];
                bit_buf  = bit_buf >> k;
                buf_bits = (buf_bits > k) ? buf_bits - k : 0;
            end
            if (in_image)
                pixels_done = pixels_done + 1'b1;
            res.kind      = KIND_PIXEL;
            res.red       = ch[0];
            res.green     = ch[1];
            res.blue      = ch[2];
            res.data_byte = '0;
            res.big       = big;
            res.last      = 1'b1;
            stego_results.push_back(res);
            return;
        end

        // extract: pixels past the end of the image give nothing
        if (!in_image)
            return;
        acc  = 64'(bit_buf);
        pend = buf_bits;
        for (int idx = 0; idx < PIX_BITS; idx++) begin
            if (pend < BUF_W) begin
                acc  = acc | (64'(ch[idx / BITS_PER_CHAN][idx % BITS_PER_CHAN]) << pend);
                pend = pend + 1;
            end
        end
        pixels_done = pixels_done + 1'b1;
        at_end      = pixels_done >= img_pixels;
        n           = 0;
        while (n < MAX_BYTES_OUT && pend >= CHAN_W && 64'(bytes_out) < cap_bits / 8) begin
            outs[n] = '{KIND_BYTE, 8'h00, 8'h00, 8'h00, acc[7:0], 1'b0, 1'b0};
            n         = n + 1;
            acc       = acc >> CHAN_W;
            pend      = pend - CHAN_W;
            bytes_out = bytes_out + 1'b1;
        end
        // partial byte flush on the last pixel, only if nothing was ever given
        if (at_end && n < MAX_BYTES_OUT && bytes_out == 0 && pend > 0 && pend < CHAN_W) begin
            outs[n] = '{KIND_BYTE, 8'h00, 8'h00, 8'h00, acc[7:0], 1'b0, 1'b0};
            n    = n + 1;
            acc  = '0;
            pend = 0;
        end
        bit_buf  = acc[BUF_W-1:0];
        buf_bits = pend;
        for (int i = 0; i < n; i++) begin
            outs[i].last = (i == n - 1);
            stego_results.push_back(outs[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        stego_res_t want;
        stego_res_t got;

        if (!rst_n) begin
            cur_mode    <= MODE_EMBED;
            img_pixels  <= CNT_W'(1);
            msg_bytes   <= '0;
            bit_buf     <= '0;
            buf_bits    <= 0;
            pixels_done <= '0;
            bytes_out   <= '0;
            fails       <= 0;
            reported    <= 0;
            stego_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:          cur_mode   = mode_t'(cfg_data[0]);
                    REG_PIXEL_TOTAL:   img_pixels = cfg_data;
                    REG_PAYLOAD_BYTES: msg_bytes  = cfg_data;
                    default: ;
                endcase
            end

            // results first: each result passes the input and result registers, so it
            // never belongs to the input transaction taken at the same edge
            if (out_valid && !out_stall) begin
                got = '{kind_t'(kind), out_red, out_green, out_blue, out_byte,
                        too_large, last_of_run};
                if (stego_results.size() == 0) begin
                    fails = fails + 1;
                    if (reported < 10) begin
                        reported = reported + 1;
                        $display("unexpected result transaction at %0t: kind %0d rgb %h %h %h",
                                 $realtime, got.kind, got.red, got.green, got.blue);
                    end
                end else begin
                    want = stego_results.pop_front();
                    if (got !== want) begin
                        fails = fails + 1;
                        if (reported < 10) begin
                            reported = reported + 1;
                            $display("mismatch at %0t: expected kind %0d rgb %h %h %h byte %h big %0d last %0d",
                                     $realtime, want.kind, want.red, want.green, want.blue,
                                     want.data_byte, want.big, want.last);
                            $display("               got      kind %0d rgb %h %h %h byte %h big %0d last %0d",
                                     got.kind, got.red, got.green, got.blue,
                                     got.data_byte, got.big, got.last);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
                stego_predict(cmd, payload_byte, in_red, in_green, in_blue);
        end
    end

endmodule

[bench/testbench.sv]
// stimulus, clock, reset and verdict for the lsb stego codec bench
`timescale 1ns / 1ps

module testbench;
    import lpsc_pkg::*;

    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_GAP   = 4;       // comfortably past the input and result registers
    localparam longint MAX_COUNT = 64'd16777216;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 cmd = 1'b0;
    logic [CHAN_W-1:0]    payload_byte = '0;
    logic [CHAN_W-1:0]    in_red = '0;
    logic [CHAN_W-1:0]    in_green = '0;
    logic [CHAN_W-1:0]    in_blue = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 kind;
    logic [CHAN_W-1:0]    out_red;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_blue;
    logic [CHAN_W-1:0]    out_byte;
    logic                 too_large;
    logic                 last_of_run;

    int fail_count;
    int pending;

    // idle profile, in percent per cycle
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // stimulus-side view of the image position, used only to shape frames
    int seen_est  = 0;
    int cur_total = 1;
    int cycles    = 0;

    always #6 clk = ~clk;

    lsb_pixel_stego_codec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .payload_byte (payload_byte),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_byte     (out_byte),
        .too_large    (too_large),
        .last_of_run  (last_of_run)
    );

    lpsc_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .payload_byte (payload_byte),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_byte     (out_byte),
        .too_large    (too_large),
        .last_of_run  (last_of_run),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // run watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic set_idle(input int profile);
        case (profile)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end  // full rate
            1: begin send_idle_pct = 85; stall_pct = 0;  end  // sparse sender
            2: begin send_idle_pct = 0;  stall_pct = 85; end  // slow receiver
            default: begin send_idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // register write, only issued while the codec is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_PIXEL_TOTAL)
            cur_total = int'(data);
    endtask

    // one input transaction; valid stays high after acceptance until the
    // next falling edge decides between a gap and the next transaction
    task automatic send_item(input cmd_t c, input logic [CHAN_W-1:0] pb,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        cmd          <= c;
        payload_byte <= pb;
        in_red       <= r;
        in_green     <= g;
        in_blue      <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_PIXEL && seen_est < cur_total)
            seen_est = seen_est + 1;
    endtask

    // drop valid, drain every predicted result, then let loads retire
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    initial begin
        int     rand_items;
        int     phase;
        int     frame_px;
        int     px_sent;
        int     extra;
        int     sel;
        int     fill_est;
        mode_t  new_mode;
        longint total;
        longint cap_bytes;
        longint payload;
        longint lo;
        longint left_bits;
        longint loaded_bits;

        rand_items = 0;
        phase      = 0;

        // reset held low, then released on a falling edge
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // ---------------- directed part ----------------
        set_idle(0);

        // embed, payload exactly filling a four-pixel image
        write_reg(REG_MODE, CNT_W'(MODE_EMBED));
        write_reg(REG_PIXEL_TOTAL, CNT_W'(4));
        write_reg(REG_PAYLOAD_BYTES, CNT_W'(3));
        send_item(CMD_LOAD, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_LOAD, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'h5A, 8'h00, 8'h00, 8'h00);
        // buffer full now, this byte is dropped
        send_item(CMD_LOAD, 8'h3C, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
        // past the end of the image, passes unchanged
        send_item(CMD_PIXEL, 8'h00, 8'h12, 8'h34, 8'h56);
        settle();

        // payload larger than capacity, largest payload first
        write_reg(REG_PIXEL_TOTAL, CNT_W'(5));
        write_reg(REG_PAYLOAD_BYTES, CNT_W'(MAX_COUNT));
        send_item(CMD_PIXEL, 8'h00, 8'hAA, 8'h55, 8'hAA);
        settle();
        write_reg(REG_PAYLOAD_BYTES, CNT_W'(4));
        send_item(CMD_PIXEL, 8'h00, 8'h0F, 8'hF0, 8'h0F);
        settle();

        // starved buffer and a partly filled last pixel
        write_reg(REG_PIXEL_TOTAL, CNT_W'(7));
        write_reg(REG_PAYLOAD_BYTES, CNT_W'(5));
        send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        settle();

        // extract, one-pixel frame: only a partial byte gets flushed
        write_reg(REG_MODE, CNT_W'(MODE_EXTRACT));
        write_reg(REG_PIXEL_TOTAL, CNT_W'(8));
        send_item(CMD_PIXEL, 8'h00, 8'hFE, 8'h01, 8'hFF);
        settle();

        // extract with a full buffer: overflow bits lost, three bytes out
        write_reg(REG_PIXEL_TOTAL, CNT_W'(12));
        send_item(CMD_LOAD, 8'h11, 8'h00, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'h22, 8'h00, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'h33, 8'h00, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'h44, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_PIXEL, 8'h00, 8'hC3, 8'h3C, 8'h96);
        send_item(CMD_PIXEL, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'h5A, 8'hA5, 8'h5A);
        // beyond the image, extract gives nothing
        send_item(CMD_PIXEL, 8'h00, 8'h77, 8'h88, 8'h99);
        settle();

        // ---------------- random frames ----------------
        while (rand_items < RANDOM_ITEMS) begin
            set_idle(phase % 4);
            frame_px = $urandom_range(2, 12);
            new_mode = $urandom_range(0, 1) ? MODE_EXTRACT : MODE_EMBED;

            // the seen count never rewinds, so each frame sits above it
            if (phase == 1)
                total = MAX_COUNT;
            else if ($urandom_range(0, 7) == 0)
                total = $urandom_range(seen_est + 1, MAX_COUNT);
            else
                total = seen_est + frame_px;
            cap_bytes = (total * PIX_BITS) / 8;
            lo        = (longint'(seen_est) * PIX_BITS) / 8 + 1;

            sel = $urandom_range(0, 9);
            if (phase == 1)
                payload = cap_bytes;                          // exact fit at the largest image
            else if (sel == 0)
                payload = 0;
            else if (sel == 1) begin
                payload = cap_bytes + 1 + $urandom_range(0, 7);  // too large
                if (payload > MAX_COUNT)
                    payload = MAX_COUNT;
            end else if (lo > cap_bytes)
                payload = cap_bytes;
            else
                payload = $urandom_range(lo, cap_bytes);

            write_reg(REG_MODE, CNT_W'(new_mode));
            write_reg(REG_PIXEL_TOTAL, CNT_W'(total));
            write_reg(REG_PAYLOAD_BYTES, CNT_W'(payload));

            // payload bits still to be placed in this frame
            if (payload * 8 > total * PIX_BITS || payload * 8 <= longint'(seen_est) * PIX_BITS)
                left_bits = 0;
            else
                left_bits = payload * 8 - longint'(seen_est) * PIX_BITS;

            loaded_bits = 0;
            fill_est    = 0;
            px_sent     = 0;
            extra       = $urandom_range(0, 2);
            while (px_sent < frame_px + extra) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any command, any content
                    sel = $urandom_range(0, 1);
                    send_item(cmd_t'(sel), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                    if (sel == 1)
                        px_sent = px_sent + 1;
                end else if (new_mode == MODE_EMBED && loaded_bits < left_bits
                             && fill_est <= LOAD_LIMIT) begin
                    // keep the bit buffer ahead of the pixel stream
                    send_item(CMD_LOAD, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                    loaded_bits = loaded_bits + 8;
                    fill_est    = fill_est + 8;
                end else begin
                    send_item(CMD_PIXEL, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                    px_sent  = px_sent + 1;
                    fill_est = (fill_est > PIX_BITS) ? fill_est - PIX_BITS : 0;
                end
                rand_items = rand_items + 1;
            end
            settle();
            phase = phase + 1;
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
